@@ rtl/ptpc_pkg.sv @@
// shared types, codes and defaults of the permutation test power counter
// no dependencies
package ptpc_pkg;

  localparam int unsigned MAX_PERMS_DEF  = 1024;
  localparam int unsigned COUNT_BITS_DEF = 20;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 32;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned PTOT_W   = 11;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned PCFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;
  localparam logic [PCFG_W-1:0]  PERMS_RESET = 11'd1024;

  // input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_OBSERVED = 2'd0,
    OP_PERMUTED = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 1'b0,
    REG_PERMS = 1'b1
  } reg_e;

  // request handed from the issue stage to the commit stage
  typedef struct packed {
    logic valid;
    logic is_read;
    logic oor;
  } req_t;

  // commit stage status
  typedef struct packed {
    logic busy;     // clearing sweep running
    logic advance;  // pipeline moves this cycle
  } status_t;

endpackage

@@ rtl/ptpc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module ptpc_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptpc_issue.sv @@
// issue stage: replication state, counter read issue, limit product
// depends on ptpc_pkg
module ptpc_issue #(
  parameter int unsigned MAX_PERMS  = ptpc_pkg::MAX_PERMS_DEF,
  parameter int unsigned COUNT_BITS = ptpc_pkg::COUNT_BITS_DEF,
  localparam int unsigned AW    = $clog2(MAX_PERMS),
  localparam int unsigned PW    = $clog2(MAX_PERMS + 1),
  localparam int unsigned PRODW = ptpc_pkg::ALPHA_W + PW + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic                               advance_i,
  input  logic [ptpc_pkg::OP_W-1:0]          op_i,
  input  logic signed [ptpc_pkg::STAT_W-1:0] stat_i,
  input  logic [ptpc_pkg::RIDX_W-1:0]        ridx_i,
  input  logic [ptpc_pkg::ALPHA_W-1:0]       alpha_i,
  input  logic [ptpc_pkg::PCFG_W-1:0]        perms_i,
  output logic                               rd_en_o,
  output logic [AW-1:0]                      rd_addr_o,
  output ptpc_pkg::req_t                     req_o,
  output logic [AW-1:0]                      addr_o,
  output logic [PW:0]                        need_o,
  output logic [PRODW-1:0]                   prod_o,
  output logic [ptpc_pkg::PTOT_W-1:0]        ptot_o,
  output logic [COUNT_BITS-1:0]              reps_o
);

  localparam int unsigned EW = (PW > ptpc_pkg::PCFG_W) ? PW : ptpc_pkg::PCFG_W;

  // replication state
  logic signed [ptpc_pkg::STAT_W-1:0] obs_q;
  logic [PW-1:0]         exceed_q, exceed_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic                  open_q, open_d;
  logic [COUNT_BITS-1:0] reps_q, reps_d;
  logic                  load_obs;

  // stage registers toward commit
  ptpc_pkg::req_t                req_q, req_d;
  logic [AW-1:0]                 addr_q;
  logic [PW:0]                   need_q;
  logic [PRODW-1:0]              prod_q;
  logic [ptpc_pkg::PTOT_W-1:0]   ptot_q;
  logic [COUNT_BITS-1:0]         reps_out_q;

  logic [EW-1:0] perms_ext, eff_n, ridx_ext;
  logic          do_upd, do_read, hit;
  logic [PW-1:0] exceed_inc;

  always_comb begin
    perms_ext = EW'(perms_i);
    if (perms_ext == '0) begin
      eff_n = EW'(1);
    end else if (perms_ext > EW'(MAX_PERMS)) begin
      eff_n = EW'(MAX_PERMS);
    end else begin
      eff_n = perms_ext;
    end
  end

  assign ridx_ext   = EW'(ridx_i);
  assign hit        = (stat_i >= obs_q);
  assign exceed_inc = exceed_q + PW'(hit);

  always_comb begin
    do_upd   = 1'b0;
    do_read  = 1'b0;
    load_obs = 1'b0;
    exceed_d = exceed_q;
    pos_d    = pos_q;
    open_d   = open_q;
    reps_d   = reps_q;
    if (accept_i) begin
      case (op_i)
        ptpc_pkg::OP_OBSERVED: begin
          load_obs = 1'b1;
          exceed_d = '0;
          pos_d    = '0;
          open_d   = 1'b1;
          reps_d   = (&reps_q) ? reps_q : reps_q + COUNT_BITS'(1);
        end
        ptpc_pkg::OP_PERMUTED: begin
          // ignored with no open replication or past the configured count
          if (open_q && (EW'(pos_q) < eff_n)) begin
            do_upd   = 1'b1;
            exceed_d = exceed_inc;
            pos_d    = pos_q + PW'(1);
          end
        end
        ptpc_pkg::OP_READ: begin
          do_read = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_en_o   = do_upd | do_read;
  assign rd_addr_o = do_read ? ridx_ext[AW-1:0] : pos_q[AW-1:0];

  always_comb begin
    req_d.valid   = do_upd | do_read;
    req_d.is_read = do_read;
    req_d.oor     = do_read & (ridx_ext >= eff_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exceed_q <= '0;
      pos_q    <= '0;
      open_q   <= 1'b0;
      reps_q   <= '0;
      obs_q    <= '0;
      req_q    <= '0;
    end else begin
      exceed_q <= exceed_d;
      pos_q    <= pos_d;
      open_q   <= open_d;
      reps_q   <= reps_d;
      if (load_obs) begin
        obs_q <= stat_i;
      end
      if (advance_i) begin
        req_q <= req_d;
      end
    end
  end

  // payload toward commit, limit product alpha * (b + 2) taken here
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      addr_q     <= rd_addr_o;
      need_q     <= (PW + 1)'(exceed_inc) + (PW + 1)'(1);
      prod_q     <= PRODW'(alpha_i) * PRODW'((PW + 1)'(pos_q) + (PW + 1)'(2));
      ptot_q     <= ptpc_pkg::PTOT_W'(ridx_i) + ptpc_pkg::PTOT_W'(1);
      reps_out_q <= reps_q;
    end
  end

  assign req_o  = req_q;
  assign addr_o = addr_q;
  assign need_o = need_q;
  assign prod_o = prod_q;
  assign ptot_o = ptot_q;
  assign reps_o = reps_out_q;

endmodule

@@ rtl/ptpc_commit.sv @@
// commit stage: clearing sweep, counter read-modify-write with forwarding,
// result register; depends on ptpc_pkg
module ptpc_commit #(
  parameter int unsigned MAX_PERMS  = ptpc_pkg::MAX_PERMS_DEF,
  parameter int unsigned COUNT_BITS = ptpc_pkg::COUNT_BITS_DEF,
  localparam int unsigned AW    = $clog2(MAX_PERMS),
  localparam int unsigned PW    = $clog2(MAX_PERMS + 1),
  localparam int unsigned PRODW = ptpc_pkg::ALPHA_W + PW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ptpc_pkg::req_t              req_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [PW:0]                 need_i,
  input  logic [PRODW-1:0]            prod_i,
  input  logic [ptpc_pkg::PTOT_W-1:0] ptot_i,
  input  logic [COUNT_BITS-1:0]       reps_i,
  input  logic [COUNT_BITS-1:0]       rd_data_i,
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [COUNT_BITS-1:0]       wdata_o,
  input  logic                        m_ready_i,
  output ptpc_pkg::status_t           status_o,
  output logic                        out_valid_o,
  output logic [ptpc_pkg::PTOT_W-1:0] out_ptot_o,
  output logic [COUNT_BITS-1:0]       out_reject_o,
  output logic [COUNT_BITS-1:0]       out_reps_o,
  output logic                        out_oor_o
);

  logic                  busy_q;
  logic [AW-1:0]         clr_q;
  logic                  fwd_valid_q;
  logic [AW-1:0]         fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                        out_valid_q;
  logic [ptpc_pkg::PTOT_W-1:0] out_ptot_q;
  logic [COUNT_BITS-1:0]       out_reject_q;
  logic [COUNT_BITS-1:0]       out_reps_q;
  logic                        out_oor_q;

  logic                  advance;
  logic [COUNT_BITS-1:0] cnt, cnt_inc;
  logic                  reject, upd_we;

  assign advance = !out_valid_q || m_ready_i;

  // last write wins over the registered read of the same entry
  assign cnt     = (fwd_valid_q && (fwd_addr_q == addr_i)) ? fwd_data_q : rd_data_i;
  assign cnt_inc = cnt + COUNT_BITS'(1);
  assign reject  = (need_i <= prod_i[PRODW-1:ptpc_pkg::ALPHA_W]);
  assign upd_we  = advance && req_i.valid && !req_i.is_read && reject && !(&cnt);

  assign we_o    = busy_q | upd_we;
  assign waddr_o = busy_q ? clr_q : addr_i;
  assign wdata_o = busy_q ? '0 : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      clr_q       <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (busy_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(MAX_PERMS - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (upd_we) begin
        fwd_valid_q <= 1'b1;
      end
      if (advance) begin
        out_valid_q <= req_i.valid && req_i.is_read;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      fwd_addr_q <= addr_i;
      fwd_data_q <= cnt_inc;
    end
    if (advance) begin
      out_ptot_q   <= ptot_i;
      out_reject_q <= req_i.oor ? '0 : cnt;
      out_reps_q   <= reps_i;
      out_oor_q    <= req_i.oor;
    end
  end

  assign status_o.busy    = busy_q;
  assign status_o.advance = advance;

  assign out_valid_o  = out_valid_q;
  assign out_ptot_o   = out_ptot_q;
  assign out_reject_o = out_reject_q;
  assign out_reps_o   = out_reps_q;
  assign out_oor_o    = out_oor_q;

endmodule

@@ rtl/permutation_test_power_counter.sv @@
// top level of the permutation test power counter
// depends on ptpc_pkg, ptpc_ram, ptpc_issue, ptpc_commit
//
// Counts, per permutation count position b, the replications of a Monte Carlo
// permutation test that reject at level alpha. An observed statistic (tuser 0)
// opens a replication; permuted statistics (tuser 1) follow in order b and each
// bumps the rejection counter of b when the number of permuted values at or
// above the observed one is at most floor(alpha*(b+2)) - 1. A read (tuser 2)
// returns one word with b+1, the counter of b, the replication count and an
// out-of-range flag; software does the final division. Statistics are signed
// Q16.16, alpha is unsigned Q0.16, counters saturate at 2^COUNT_BITS-1.
// Rate: one word per cycle, back to back, while the input is not stalled. The
// issue stage reads the counter memory and forms alpha*(b+2), the commit stage
// compares and writes the counter back; a write followed at once by a read of
// the same counter is forwarded. A read result passes the issue stage register
// on its way into the output register. Outside the clearing sweep, input stalls
// only while a result is held in the output register and the master side is not
// ready. After reset the counter memory is cleared in a sweep, one entry per
// cycle, with tready low; configuration writes are taken throughout.
module permutation_test_power_counter #(
  parameter int unsigned MAX_PERMS  = ptpc_pkg::MAX_PERMS_DEF,
  parameter int unsigned COUNT_BITS = ptpc_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // slave side
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [47:0]                            s_axis_tdata,  // stat_value, read_index
  input  logic [ptpc_pkg::OP_W-1:0]              s_axis_tuser,  // operation
  // master side
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // perm_total, reject_count, replication_count, index_out_of_range
  output logic [((2*COUNT_BITS+12+7)/8)*8-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [ptpc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [ptpc_pkg::CFG_DAT_W-1:0]         cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_PERMS);
  localparam int unsigned PW    = $clog2(MAX_PERMS + 1);
  localparam int unsigned PRODW = ptpc_pkg::ALPHA_W + PW + 1;
  localparam int unsigned RES_W = ptpc_pkg::PTOT_W + 2 * COUNT_BITS + 1;
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

  // configuration registers
  logic [ptpc_pkg::ALPHA_W-1:0] alpha_q;
  logic [ptpc_pkg::PCFG_W-1:0]  perms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ptpc_pkg::ALPHA_RESET;
      perms_q <= ptpc_pkg::PERMS_RESET;
    end else if (cfg_we_i) begin
      unique case (ptpc_pkg::reg_e'(cfg_idx_i))
        ptpc_pkg::REG_ALPHA: alpha_q <= cfg_data_i;
        ptpc_pkg::REG_PERMS: perms_q <= cfg_data_i[ptpc_pkg::PCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input word fields
  logic signed [ptpc_pkg::STAT_W-1:0] stat;
  logic [ptpc_pkg::RIDX_W-1:0]        ridx;
  logic                               accept;

  assign stat = $signed(s_axis_tdata[ptpc_pkg::STAT_W-1:0]);
  assign ridx = s_axis_tdata[ptpc_pkg::STAT_W +: ptpc_pkg::RIDX_W];

  ptpc_pkg::status_t status;
  ptpc_pkg::req_t    req;

  // accept only outside the clearing sweep and when the pipeline moves
  assign s_axis_tready = status.advance && !status.busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // memory ports
  logic                  ram_re, ram_we;
  logic [AW-1:0]         ram_raddr, ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  // issue to commit payload
  logic [AW-1:0]               s1_addr;
  logic [PW:0]                 s1_need;
  logic [PRODW-1:0]            s1_prod;
  logic [ptpc_pkg::PTOT_W-1:0] s1_ptot;
  logic [COUNT_BITS-1:0]       s1_reps;

  // result register outputs
  logic [ptpc_pkg::PTOT_W-1:0] res_ptot;
  logic [COUNT_BITS-1:0]       res_reject, res_reps;
  logic                        res_oor;

  ptpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_PERMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptpc_issue #(
    .MAX_PERMS  (MAX_PERMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_issue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (status.advance),
    .op_i      (s_axis_tuser),
    .stat_i    (stat),
    .ridx_i    (ridx),
    .alpha_i   (alpha_q),
    .perms_i   (perms_q),
    .rd_en_o   (ram_re),
    .rd_addr_o (ram_raddr),
    .req_o     (req),
    .addr_o    (s1_addr),
    .need_o    (s1_need),
    .prod_o    (s1_prod),
    .ptot_o    (s1_ptot),
    .reps_o    (s1_reps)
  );

  ptpc_commit #(
    .MAX_PERMS  (MAX_PERMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_commit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .addr_i       (s1_addr),
    .need_i       (s1_need),
    .prod_i       (s1_prod),
    .ptot_i       (s1_ptot),
    .reps_i       (s1_reps),
    .rd_data_i    (ram_rdata),
    .we_o         (ram_we),
    .waddr_o      (ram_waddr),
    .wdata_o      (ram_wdata),
    .m_ready_i    (m_axis_tready),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ptot_o   (res_ptot),
    .out_reject_o (res_reject),
    .out_reps_o   (res_reps),
    .out_oor_o    (res_oor)
  );

  // result word, first field in the low bits, zero filled to whole bytes
  assign m_axis_tdata = OUT_W'({res_oor, res_reps, res_reject, res_ptot});

`ifndef NO_ASSERTIONS
  // an accepted read reaches the commit stage on the next cycle
  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == ptpc_pkg::OP_READ) |=> req.valid && req.is_read)
    else $error("accepted read did not reach commit stage");

  // counter updates are only written when the pipeline moves
  a_write_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && !status.busy |-> status.advance)
    else $error("counter write during stall");

  // no result can leave during the clearing sweep
  a_no_result_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !m_axis_tvalid && !req.valid)
    else $error("pipeline active during clearing sweep");

  // sweep ends with an empty pipeline
  a_sweep_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(status.busy) |-> !req.valid && !m_axis_tvalid)
    else $error("work in flight when clearing sweep ended");
`endif

endmodule

@@ bench/tb.sv @@
// testbench for the permutation test power counter: directed and random words
// against a cycle-free predictor of the per-position rejection tallies
// depends on ptpc_pkg and the permutation_test_power_counter rtl
`timescale 1ns / 100ps

module tb;
  import ptpc_pkg::*;

  localparam int unsigned PERMS      = MAX_PERMS_DEF;
  localparam int unsigned CNT_W      = COUNT_BITS_DEF;
  localparam int unsigned OUT_W      = ((2*CNT_W+12+7)/8)*8;
  localparam int unsigned STALL_LIMIT = 6000;  // clearing sweep plus worst stalls, several times
  localparam int unsigned SETTLE_CYCLES = 4;   // two stages in flight, with margin

  // operation code the block does not decode
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] STAT_MIN = 32'h8000_0000;
  localparam logic [STAT_W-1:0] STAT_MAX = 32'h7fff_ffff;

  // one read result, fields as they come out of the block
  typedef struct packed {
    logic                oor;
    logic [CNT_W-1:0]    reps;
    logic [CNT_W-1:0]    rejects;
    logic [PTOT_W-1:0]   perm_total;
  } readout_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // slave side, driven at the falling edge
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [47:0]       s_tdata  = '0;  // stat_value, read_index
  logic [OP_W-1:0]   s_tuser  = '0;  // operation

  // master side
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // perm_total, reject_count, replication_count, index_out_of_range
  logic [OUT_W-1:0]  m_tdata;

  // register writes
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;

  // idle rates in percent, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // predictor state: rejection tallies per position, the open replication and the registers
  logic [CNT_W-1:0]         reject_tally [PERMS];
  logic signed [STAT_W-1:0] obs_level;
  logic [PTOT_W-1:0]        at_or_above;
  logic [PTOT_W-1:0]        next_b;
  logic [CNT_W-1:0]         reps_started;
  logic                     rep_open;
  logic [ALPHA_W-1:0]       alpha_q;
  logic [PCFG_W-1:0]        perms_reg;

  // read results predicted but not yet seen on the master side
  readout_t expected_reads [$];

  // statistic that opened the replication being sent, used to shape permuted values
  logic [STAT_W-1:0] cur_obs_stat = '0;

  permutation_test_power_counter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // receiver backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // permutation count in force: zero reads as one, anything above the memory depth clips
  function automatic int unsigned eff_perms();
    if (perms_reg == '0) return 1;
    if (perms_reg > PERMS) return PERMS;
    return perms_reg;
  endfunction

  function automatic void clear_tallies();
    foreach (reject_tally[i]) reject_tally[i] = '0;
    obs_level    = '0;
    at_or_above  = '0;
    next_b       = '0;
    reps_started = '0;
    rep_open     = 1'b0;
    alpha_q      = ALPHA_RESET;
    perms_reg    = PERMS_RESET;
  endfunction

  // advance the tallies by one accepted word; a read queues its expected result
  function automatic void tally_word(logic [OP_W-1:0] op, logic [47:0] data);
    logic signed [STAT_W-1:0] stat;
    logic [RIDX_W-1:0]        ridx;
    int unsigned              n;
    int unsigned              threshold;
    readout_t                 want;
    stat = data[STAT_W-1:0];
    ridx = data[STAT_W +: RIDX_W];
    n    = eff_perms();
    case (op)
      OP_OBSERVED: begin
        obs_level   = stat;
        at_or_above = '0;
        next_b      = '0;
        rep_open    = 1'b1;
        if (reps_started != '1) reps_started = reps_started + 1'b1;
      end
      OP_PERMUTED: begin
        // stray permuted words (none open, or past the count) leave no trace
        if (rep_open && next_b < n) begin
          if (stat >= obs_level) at_or_above = at_or_above + 1'b1;
          // floor(alpha*(b+2)) from the exact Q0.16 product
          threshold = (int'(alpha_q) * (int'(next_b) + 2)) >> 16;
          if (int'(at_or_above) + 1 <= threshold && reject_tally[next_b[RIDX_W-1:0]] != '1)
            reject_tally[next_b[RIDX_W-1:0]] = reject_tally[next_b[RIDX_W-1:0]] + 1'b1;
          next_b = next_b + 1'b1;
        end
      end
      OP_READ: begin
        want.perm_total = PTOT_W'(ridx) + 1'b1;
        want.oor        = (ridx >= n);
        want.rejects    = want.oor ? '0 : reject_tally[ridx];
        want.reps       = reps_started;
        expected_reads.push_back(want);
      end
      default: ;  // unused code, ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("tb: %0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // results are checked before the word accepted at the same edge is predicted,
  // so a surplus result can never pair with a fresh expectation
  always @(posedge clk_i) begin : capture
    readout_t got;
    readout_t want;
    if (m_tvalid && m_tready) begin
      got = m_tdata[$bits(readout_t)-1:0];
      if (expected_reads.size() == 0) begin
        report_mismatch("word with nothing pending", got.perm_total, 0);
      end else begin
        want = expected_reads.pop_front();
        if (got.perm_total != want.perm_total)
          report_mismatch("perm_total", got.perm_total, want.perm_total);
        if (got.rejects != want.rejects)
          report_mismatch("reject_count", got.rejects, want.rejects);
        if (got.reps != want.reps)
          report_mismatch("replication_count", got.reps, want.reps);
        if (got.oor != want.oor)
          report_mismatch("index_out_of_range", got.oor, want.oor);
      end
    end
    if (s_tvalid && s_tready) tally_word(s_tuser, s_tdata);
  end

  // watchdog: too long without a word moving on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one word on the slave side, with random idle cycles ahead of it
  task automatic send_word(logic [OP_W-1:0] op, logic [STAT_W-1:0] stat,
                           logic [RIDX_W-1:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, ridx, stat};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // stop sending, let every pending read come back and the pipe empty out
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (expected_reads.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write, only called with nothing in flight
  task automatic write_reg(reg_e idx, logic [CFG_DAT_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == REG_ALPHA) alpha_q = data;
    else                  perms_reg = data[PCFG_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // perms written with random junk above the register width
  task automatic write_perms(logic [PCFG_W-1:0] perms);
    write_reg(REG_PERMS, {5'($urandom), perms});
  endtask

  // mostly reads near the live count so both sides of the range edge show up
  function automatic logic [RIDX_W-1:0] pick_index();
    int unsigned hi;
    hi = eff_perms() + 1;
    if (hi > PERMS - 1) hi = PERMS - 1;
    if ($urandom_range(4) != 0) return RIDX_W'($urandom_range(hi));
    return RIDX_W'($urandom_range(PERMS - 1));
  endfunction

  // permuted value around the observed one: equal, a bit above, below, or anything
  function automatic logic [STAT_W-1:0] pick_perm_stat();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return cur_obs_stat;
      2, 3, 4: return cur_obs_stat + $urandom_range(1, 65536 * 4);
      default: return cur_obs_stat - $urandom_range(0, 65536 * 8);
    endcase
  endfunction

  function automatic logic [STAT_W-1:0] pick_obs_stat();
    if ($urandom_range(1) == 0) return $urandom;
    return $urandom_range(1 << 20) - (1 << 19);
  endfunction

  // one replication: observed word, then its permuted words, reads mixed in;
  // now and then cut short or run past the count
  task automatic send_replication(int unsigned n, ref int unsigned sent);
    cur_obs_stat = pick_obs_stat();
    send_word(OP_OBSERVED, cur_obs_stat, RIDX_W'($urandom));
    sent++;
    for (int unsigned b = 0; b < n; b++) begin
      send_word(OP_PERMUTED, pick_perm_stat(), RIDX_W'($urandom));
      sent++;
      if ($urandom_range(99) < 15) begin
        send_word(OP_READ, $urandom, pick_index());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked words: extremes of every field, every code and each corner case
  task automatic test_directed();
    write_reg(REG_ALPHA, 16'hffff);  // alpha just below one: threshold is b+1
    write_perms(11'd4);
    // reads with nothing counted yet, one of them out of range
    send_word(OP_READ, 32'h0, 10'd0);
    send_word(OP_READ, 32'hffff_ffff, 10'd1023);
    // permuted word before any observed one is dropped
    send_word(OP_PERMUTED, STAT_MAX, 10'd0);
    // unused code gives nothing back
    send_word(OP_UNUSED, 32'hffff_ffff, 10'h3ff);
    // lowest observed value: every permuted value counts as at or above
    send_word(OP_OBSERVED, STAT_MIN, 10'd0);
    send_word(OP_PERMUTED, STAT_MAX, 10'd0);
    send_word(OP_PERMUTED, STAT_MIN, 10'd0);  // equal counts too
    send_word(OP_PERMUTED, 32'h0, 10'd0);
    send_word(OP_PERMUTED, 32'hffff_0000, 10'd0);
    send_word(OP_PERMUTED, 32'h0, 10'd0);     // one past the count, dropped
    // highest observed value: rejections at b = 0 and 1
    send_word(OP_OBSERVED, STAT_MAX, 10'd0);
    send_word(OP_PERMUTED, 32'h7fff_fffe, 10'd0);
    send_word(OP_PERMUTED, STAT_MAX, 10'd0);
    // restart in the middle: earlier tallies stay
    send_word(OP_OBSERVED, 32'h0001_0000, 10'd0);
    send_word(OP_PERMUTED, 32'hffff_0000, 10'd0);
    send_word(OP_READ, 32'h0, 10'd0);
    send_word(OP_READ, 32'h0, 10'd1);
    send_word(OP_READ, 32'h0, 10'd3);
    send_word(OP_READ, 32'h0, 10'd4);          // first index out of range
    send_word(OP_READ, 32'h0, 10'h3ff);
    settle_idle();
  endtask

  // register setting for the k-th random stretch, extremes included
  task automatic pick_setting(int unsigned k);
    case (k % 6)
      0: begin write_reg(REG_ALPHA, 16'h0);  write_perms(11'd1); end
      1: begin write_reg(REG_ALPHA, 16'hffff); write_perms(PCFG_W'($urandom_range(2, 12))); end
      2: begin write_reg(REG_ALPHA, CFG_DAT_W'($urandom)); write_perms(11'd0); end
      3: begin
        write_reg(REG_ALPHA, CFG_DAT_W'($urandom_range(2000, 30000)));
        write_perms(PCFG_W'($urandom_range(2, 24)));
      end
      4: begin write_reg(REG_ALPHA, CFG_DAT_W'($urandom)); write_perms(11'h7ff); end
      default: begin
        write_reg(REG_ALPHA, CFG_DAT_W'($urandom_range(20000, 65535)));
        write_perms(PCFG_W'($urandom_range(25, 64)));
      end
    endcase
  endtask

  // random traffic over several settings under one pair of idle rates
  task automatic test_random_traffic(int unsigned snd_pct, int unsigned rcv_pct,
                                     int unsigned first_setting);
    int unsigned sent;
    int unsigned n;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int unsigned k = first_setting; k < first_setting + 4; k++) begin
      pick_setting(k);
      sent = 0;
      while (sent < 80) begin
        case ($urandom_range(19))
          0: send_word(OP_UNUSED, $urandom, RIDX_W'($urandom));
          1: send_word(OP_PERMUTED, $urandom, RIDX_W'($urandom));  // stray
          2: send_word(OP_READ, $urandom, pick_index());
          default: begin
            n = eff_perms();
            // keep long counts short within the item budget
            if (n > 64) n = $urandom_range(4, 40);
            if ($urandom_range(9) == 0) n = $urandom_range(0, n + 3);
            send_replication(n, sent);
            send_word(OP_READ, $urandom, pick_index());
          end
        endcase
        sent++;
      end
      settle_idle();
    end
  endtask

  // one replication over the whole memory depth, then reads spread across it
  task automatic test_full_depth();
    int unsigned sent;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_ALPHA, CFG_DAT_W'($urandom_range(8000, 65535)));
    write_reg(REG_PERMS, 16'hffff);  // clips to the memory depth
    sent = 0;
    send_replication(PERMS + 1, sent);
    send_word(OP_READ, $urandom, 10'd1023);
    for (int i = 0; i < 24; i++) send_word(OP_READ, $urandom, RIDX_W'($urandom));
    settle_idle();
  endtask

  initial begin
    clear_tallies();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    // clearing sweep runs with tready low; the first send simply waits it out
    test_directed();
    test_random_traffic(36, 78, 0);
    test_random_traffic(78, 36, 4);
    test_random_traffic(0, 0, 8);
    test_full_depth();
    // settle_idle above has already drained; let the pipe idle again before the final check
    repeat (SETTLE_CYCLES * 2) @(negedge clk_i);
    if (expected_reads.size() != 0)
      report_mismatch("reads never answered", expected_reads.size(), 0);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
